>>> sv/tth_pkg.sv
`default_nettype none

package tth_pkg;

  localparam int WINDOW_DEPTH_DEF = 64;
  localparam int MIN_ENTRIES      = 60;
  localparam int CORDIC_STEPS     = 18;
  localparam int POS_W            = 15;
  localparam int ENTRY_W          = 3 * POS_W;
  localparam int LOOKBACK_W       = 7;
  localparam int OPD_W            = 16;
  localparam int CR_W             = 26;
  localparam int ACC_W            = 22;
  localparam int STEP_W           = 5;
  localparam int RAD_W            = 30;
  localparam int ROOT_W           = 15;
  localparam int REM_W            = 17;

  localparam logic [LOOKBACK_W-1:0] LOOKBACK_RESET = 7'd30;

  localparam logic signed [ACC_W-1:0] ANG_PI      = 22'sd411775;
  localparam logic signed [ACC_W-1:0] ANG_HALF_PI = 22'sd205887;
  localparam logic signed [ACC_W-1:0] ANG_TWO_PI  = 22'sd823550;
  localparam logic [15:0]             HEADING_WRAP = 16'd51472;

  // arctangent of 2^-k in 2^-17 rad units
  function automatic logic signed [ACC_W-1:0] atan_entry(input logic [STEP_W-1:0] k);
    logic signed [ACC_W-1:0] v;
    case (k)
      5'd0:    v = 22'sd102944;
      5'd1:    v = 22'sd60771;
      5'd2:    v = 22'sd32110;
      5'd3:    v = 22'sd16299;
      5'd4:    v = 22'sd8181;
      5'd5:    v = 22'sd4095;
      5'd6:    v = 22'sd2048;
      5'd7:    v = 22'sd1024;
      5'd8:    v = 22'sd512;
      5'd9:    v = 22'sd256;
      5'd10:   v = 22'sd128;
      5'd11:   v = 22'sd64;
      5'd12:   v = 22'sd32;
      5'd13:   v = 22'sd16;
      5'd14:   v = 22'sd8;
      5'd15:   v = 22'sd4;
      5'd16:   v = 22'sd2;
      5'd17:   v = 22'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> sv/torso_track_heading_core.sv
`default_nettype none

// Torso track core: each input transfer carries one torso position (x, y, z in mm) that is
// pushed into a rolling window held in a single-port-write, one-read synchronous memory of
// WINDOW_DEPTH entries. The result transfer gives the floor distance sqrt(x^2+z^2), the facing
// angle atan(x/z) and the heading of the displacement against the entry lookback-1 frames back
// (angles at 8192 units per radian), the heading valid flag and the in-frame flag. An item
// passes these steps before the next input can be taken: the accept, two memory reads
// (previous entry, then the lookback entry), the facing pass of the shared CORDIC, a reload,
// the heading pass of the CORDIC and the output load, which waits for a free output register;
// the square root runs bit-serially beside the first CORDIC pass. A finished result waits in
// the output register while the next input is taken and worked on. The user must write the
// lookback register only while the block is idle; the block does not enforce it. Lookback 0,
// above 64 or beyond the stored count, or under 60 stored entries give heading_valid low.
module torso_track_heading_core #(
  parameter int WINDOW_DEPTH = tth_pkg::WINDOW_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // pos_x [14:0], pos_y [29:15], pos_z [44:30], zero [47:45]
  input  wire logic [47:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // floor_distance [14:0], facing_angle [29:15], heading [45:30],
  // heading_valid [46], in_frame [47]
  output logic [47:0]      m_axis_tdata,
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_wdata
);

  localparam int SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int CMP_W  = (CNT_W > tth_pkg::LOOKBACK_W) ? CNT_W : tth_pkg::LOOKBACK_W;
  localparam int ADR_W  = ((SLOT_W > tth_pkg::LOOKBACK_W) ? SLOT_W : tth_pkg::LOOKBACK_W) + 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(WINDOW_DEPTH);
  localparam logic [CMP_W-1:0]  MIN_CNT   = CMP_W'(tth_pkg::MIN_ENTRIES);
  localparam logic [tth_pkg::STEP_W-1:0] LAST_STEP = 5'(tth_pkg::CORDIC_STEPS - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RDPREV = 3'd1;
  localparam logic [2:0] S_RDOLD  = 3'd2;
  localparam logic [2:0] S_FACE   = 3'd3;
  localparam logic [2:0] S_HLOAD  = 3'd4;
  localparam logic [2:0] S_HEAD   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state;
  logic [6:0] lookback;
  logic [SLOT_W-1:0] write_slot;
  logic [SLOT_W-1:0] newest;
  logic [CNT_W-1:0]  stored_count;

  logic [tth_pkg::ENTRY_W-1:0] mem [WINDOW_DEPTH];
  logic [tth_pkg::ENTRY_W-1:0] rdata;
  logic [SLOT_W-1:0] raddr;

  logic signed [tth_pkg::POS_W-1:0] px, py, pz;
  logic signed [tth_pkg::POS_W-1:0] ox, oz;
  logic signed [tth_pkg::OPD_W-1:0] dx, dz;
  logic [28:0] sq_x, sq_z;
  logic in_frame;
  logic hv;
  logic [14:0] fa;

  logic accept;
  assign s_axis_tready = (state == S_IDLE) && !rst;
  assign accept = s_axis_tvalid && s_axis_tready;

  // lookback register
  always_ff @(posedge clk) begin
    if (rst) begin
      lookback <= tth_pkg::LOOKBACK_RESET;
    end else if (cfg_we) begin
      lookback <= cfg_wdata;
    end
  end

  // window address arithmetic
  logic [SLOT_W-1:0] prev_slot;
  logic [SLOT_W-1:0] old_slot;
  logic [ADR_W-1:0]  newest_e, off_e, diff_e;
  logic [CMP_W-1:0]  cnt_e, lb_e;
  logic              hv_c;

  assign prev_slot = (write_slot == '0) ? LAST_SLOT : write_slot - 1'b1;
  assign cnt_e     = CMP_W'(stored_count);
  assign lb_e      = CMP_W'(lookback);
  assign hv_c      = (cnt_e >= MIN_CNT) && (lookback != '0) && (lb_e <= cnt_e);
  assign newest_e  = ADR_W'(newest);
  assign off_e     = ADR_W'(lookback) - 1'b1;

  always_comb begin
    diff_e = newest_e - off_e;
    if (newest_e < off_e) begin
      diff_e = newest_e + ADR_W'(WINDOW_DEPTH) - off_e;
    end
    old_slot = hv_c ? diff_e[SLOT_W-1:0] : newest;
    raddr    = (state == S_IDLE) ? prev_slot : old_slot;
  end

  // window memory
  always_ff @(posedge clk) begin
    if (accept) begin
      mem[write_slot] <= s_axis_tdata[tth_pkg::ENTRY_W-1:0];
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot   <= '0;
      stored_count <= '0;
    end else if (accept) begin
      write_slot <= (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
      if (stored_count != FULL_CNT) begin
        stored_count <= stored_count + 1'b1;
      end
    end
  end

  // cordic operand select and preload
  logic [tth_pkg::STEP_W-1:0] cstep;
  logic signed [tth_pkg::OPD_W-1:0] ly, lx;
  logic signed [tth_pkg::CR_W-1:0]  ly_e, lx_e, cx_ld, cy_ld;
  logic signed [tth_pkg::ACC_W-1:0] acc_ld;
  logic spec_ld;

  always_comb begin
    if (state == S_RDPREV) begin
      ly = pz[tth_pkg::POS_W-1] ? -tth_pkg::OPD_W'(px) : tth_pkg::OPD_W'(px);
      lx = pz[tth_pkg::POS_W-1] ? -tth_pkg::OPD_W'(pz) : tth_pkg::OPD_W'(pz);
    end else begin
      ly = dz;
      lx = dx;
    end
    ly_e    = tth_pkg::CR_W'(ly);
    lx_e    = tth_pkg::CR_W'(lx);
    spec_ld = 1'b0;
    acc_ld  = '0;
    cx_ld   = lx_e <<< 8;
    cy_ld   = ly_e <<< 8;
    if (ly == '0) begin
      spec_ld = 1'b1;
      acc_ld  = (lx < 0) ? tth_pkg::ANG_PI : '0;
    end else if (lx == '0) begin
      spec_ld = 1'b1;
      acc_ld  = (ly > 0) ? tth_pkg::ANG_HALF_PI : -tth_pkg::ANG_HALF_PI;
    end else if (lx < 0) begin
      // left half plane: rotate by pi first
      acc_ld = (ly >= 0) ? tth_pkg::ANG_PI : -tth_pkg::ANG_PI;
      cx_ld  = (-lx_e) <<< 8;
      cy_ld  = (-ly_e) <<< 8;
    end
  end

  // shared cordic, vectoring mode, one step a cycle
  logic signed [tth_pkg::CR_W-1:0]  cx, cy, sx, sy;
  logic signed [tth_pkg::ACC_W-1:0] acc;
  logic cspec;
  logic running;

  assign sx      = cx >>> cstep;
  assign sy      = cy >>> cstep;
  assign running = (state == S_FACE) || (state == S_HEAD);

  always_ff @(posedge clk) begin
    if ((state == S_RDPREV) || (state == S_HLOAD)) begin
      cx    <= cx_ld;
      cy    <= cy_ld;
      acc   <= acc_ld;
      cspec <= spec_ld;
    end else if (running && !cspec) begin
      if (cy > 0) begin
        cx  <= cx + sy;
        cy  <= cy - sx;
        acc <= acc + tth_pkg::atan_entry(cstep);
      end else begin
        cx  <= cx - sy;
        cy  <= cy + sx;
        acc <= acc - tth_pkg::atan_entry(cstep);
      end
    end
  end

  // bit-serial square root beside the facing pass
  logic [tth_pkg::RAD_W-1:0]  rad;
  logic [tth_pkg::ROOT_W-1:0] root;
  logic [tth_pkg::REM_W-1:0]  rem;
  logic [tth_pkg::REM_W+1:0]  rem_sh, trial;

  assign rem_sh = {rem, rad[tth_pkg::RAD_W-1 -: 2]};
  assign trial  = (tth_pkg::REM_W+2)'({root, 2'b01});

  always_ff @(posedge clk) begin
    if ((state == S_FACE) && (cstep == '0)) begin
      rad  <= tth_pkg::RAD_W'(sq_x) + tth_pkg::RAD_W'(sq_z);
      root <= '0;
      rem  <= '0;
    end else if ((state == S_FACE) && (cstep <= 5'(tth_pkg::ROOT_W))) begin
      rad <= rad << 2;
      if (rem_sh >= trial) begin
        rem  <= tth_pkg::REM_W'(rem_sh - trial);
        root <= {root[tth_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[tth_pkg::REM_W-1:0];
        root <= {root[tth_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  // angle rounding
  logic signed [tth_pkg::ACC_W-1:0] mag, rnd, fa_c, ha, hr;
  logic [15:0] hd_c;

  always_comb begin
    mag  = (acc < 0) ? -acc : acc;
    rnd  = (mag + 22'sd8) >>> 4;
    fa_c = (acc < 0) ? -rnd : rnd;
    ha   = (acc < 0) ? acc + tth_pkg::ANG_TWO_PI : acc;
    hr   = (ha + 22'sd8) >>> 4;
    hd_c = hr[15:0];
    if (!hv || (hd_c >= tth_pkg::HEADING_WRAP)) begin
      hd_c = '0;
    end
  end

  // per-item datapath registers
  logic [14:0] ax, az;
  assign ax = px[tth_pkg::POS_W-1] ? 15'(-px) : px;
  assign az = pz[tth_pkg::POS_W-1] ? 15'(-pz) : pz;
  assign ox = rdata[tth_pkg::POS_W-1:0];
  assign oz = rdata[3*tth_pkg::POS_W-1 -: tth_pkg::POS_W];

  always_ff @(posedge clk) begin
    if (accept) begin
      px     <= s_axis_tdata[14:0];
      py     <= s_axis_tdata[29:15];
      pz     <= s_axis_tdata[44:30];
      newest <= write_slot;
    end
    if (state == S_RDPREV) begin
      in_frame <= (stored_count >= CNT_W'(2)) && (rdata != {pz, py, px});
      hv       <= hv_c;
      sq_x     <= 29'({14'd0, ax} * {14'd0, ax});
    end
    if (state == S_RDOLD) begin
      dx   <= tth_pkg::OPD_W'(px) - tth_pkg::OPD_W'(ox);
      dz   <= tth_pkg::OPD_W'(pz) - tth_pkg::OPD_W'(oz);
      sq_z <= 29'({14'd0, az} * {14'd0, az});
    end
    if (state == S_HLOAD) begin
      fa <= fa_c[14:0];
    end
  end

  // sequencer
  logic out_free;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cstep <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) state <= S_RDPREV;
        end
        S_RDPREV: state <= S_RDOLD;
        S_RDOLD: begin
          state <= S_FACE;
          cstep <= '0;
        end
        S_FACE: begin
          if (cstep == LAST_STEP) begin
            state <= S_HLOAD;
          end else begin
            cstep <= cstep + 1'b1;
          end
        end
        S_HLOAD: begin
          state <= S_HEAD;
          cstep <= '0;
        end
        S_HEAD: begin
          if (cstep == LAST_STEP) begin
            state <= S_DONE;
          end else begin
            cstep <= cstep + 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      m_axis_tdata <= {in_frame, hv, hd_c, fa, root};
    end
  end

endmodule

`default_nettype wire

>>> sv/tth_chk.sv
`default_nettype none

module tth_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [47:0] s_axis_tdata,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata
);

  logic [14:0] floor_distance;
  logic signed [14:0] facing_angle;
  logic [15:0] heading;
  logic heading_valid;

  assign floor_distance = m_axis_tdata[14:0];
  assign facing_angle   = m_axis_tdata[29:15];
  assign heading        = m_axis_tdata[45:30];
  assign heading_valid  = m_axis_tdata[46];

  // result held until transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed before transfer");

  // one item at a time: input closes after a transfer
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while item in flight");

  a_heading_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !heading_valid |-> heading == 16'd0)
    else $error("heading not zero while not valid");

  a_ranges: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (heading < 16'd51472) && (floor_distance <= 15'd23170)
      && (facing_angle >= -15'sd12868) && (facing_angle <= 15'sd12868))
    else $error("result field out of range");

endmodule

bind torso_track_heading_core tth_chk u_tth_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> test/tth_track_checker.sv
`timescale 1ns / 100ps

module tth_track_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  // pos_x [14:0], pos_y [29:15], pos_z [44:30], zero [47:45]
  input  wire logic [47:0] s_axis_tdata,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // floor_distance [14:0], facing_angle [29:15], heading [45:30],
  // heading_valid [46], in_frame [47]
  input  wire logic [47:0] m_axis_tdata,
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_wdata,
  output int               fail_count,
  output int               pending_count,
  output int               result_count,
  output int               valid_count
);

  localparam int     DEPTH         = 64;
  localparam int     MIN_FILL      = 60;
  localparam int     ROTATIONS     = 18;
  localparam int     PRINT_CAP     = 50;
  localparam int     EXPECT_DEPTH  = 16;
  localparam longint Q17_PI        = 411775;
  localparam longint Q17_HALF_PI   = 205887;
  localparam longint Q17_TWO_PI    = 823550;
  localparam longint HEADING_LIMIT = 51472;
  localparam longint ATAN_Q17 [ROTATIONS] = '{
    102944, 60771, 32110, 16299, 8181, 4095, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2, 1
  };

  // field order matches the result tdata layout, msb first
  typedef struct packed {
    logic        in_frame;
    logic        heading_valid;
    logic [15:0] heading;
    logic [14:0] facing_angle;
    logic [14:0] floor_distance;
  } track_result_t;

  logic signed [14:0] track_x [DEPTH];
  logic signed [14:0] track_y [DEPTH];
  logic signed [14:0] track_z [DEPTH];
  int unsigned        next_slot;
  int unsigned        fill_level;
  logic [6:0]         lookback;
  // ring of expected results, oldest at exp_head
  track_result_t      expected_ring [EXPECT_DEPTH];
  int unsigned        exp_head;
  int unsigned        exp_tail;
  int unsigned        exp_used;

  // atan2(y, x) in 2^-17 rad, range (-pi, pi]
  function automatic longint vector_angle(longint y_in, longint x_in);
    longint acc;
    longint vx;
    longint vy;
    longint sx;
    longint sy;
    acc = 0;
    vx  = x_in;
    vy  = y_in;
    if (vy == 0) return (vx < 0) ? Q17_PI : 0;
    if (vx == 0) return (vy > 0) ? Q17_HALF_PI : -Q17_HALF_PI;
    if (vx < 0) begin
      acc = (vy >= 0) ? Q17_PI : -Q17_PI;
      vx  = -vx;
      vy  = -vy;
    end
    vx = vx * 256;
    vy = vy * 256;
    for (int i = 0; i < ROTATIONS; i++) begin
      sx = vx >>> i;
      sy = vy >>> i;
      if (vy > 0) begin
        vx  = vx + sy;
        vy  = vy - sx;
        acc = acc + ATAN_Q17[i];
      end else begin
        vx  = vx - sy;
        vy  = vy + sx;
        acc = acc - ATAN_Q17[i];
      end
    end
    return acc;
  endfunction

  function automatic longint floor_root(longint v);
    longint root;
    longint trial;
    root = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (64'sd1 <<< b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (fail_count < PRINT_CAP) begin
      $display("%0t mismatch on result %0d, %s: got %0d, expected %0d",
               $time, result_count, what, got, want);
    end
    fail_count++;
  endtask

  task automatic predict_track(input logic [47:0] d);
    logic signed [14:0] px;
    logic signed [14:0] py;
    logic signed [14:0] pz;
    longint             ax;
    longint             az;
    longint             dx;
    longint             dz;
    longint             ang;
    longint             mag;
    longint             rnd;
    int unsigned        newest;
    int unsigned        back;
    int unsigned        prev;
    track_result_t      r;
    px = d[14:0];
    py = d[29:15];
    pz = d[44:30];
    track_x[next_slot] = px;
    track_y[next_slot] = py;
    track_z[next_slot] = pz;
    newest    = next_slot;
    next_slot = (next_slot + 1) % DEPTH;
    if (fill_level < DEPTH) fill_level++;

    r  = '0;
    ax = longint'(px);
    az = longint'(pz);
    r.floor_distance = 15'(floor_root(ax * ax + az * az));

    // behind the sensor the pair is mirrored so the result stays atan(x/z)
    ang = (az < 0) ? vector_angle(-ax, -az) : vector_angle(ax, az);
    mag = (ang < 0) ? -ang : ang;
    rnd = (mag + 8) >>> 4;
    r.facing_angle = 15'((ang < 0) ? -rnd : rnd);

    if (fill_level >= MIN_FILL && lookback >= 1 && lookback <= fill_level) begin
      back = (newest + DEPTH - (lookback - 1)) % DEPTH;
      dx   = longint'(track_x[newest]) - longint'(track_x[back]);
      dz   = longint'(track_z[newest]) - longint'(track_z[back]);
      ang  = vector_angle(dz, dx);
      if (ang < 0) ang = ang + Q17_TWO_PI;
      rnd = (ang + 8) >>> 4;
      // rounding up to a full turn folds back to zero
      if (rnd >= HEADING_LIMIT) rnd = 0;
      r.heading       = 16'(rnd);
      r.heading_valid = 1'b1;
    end

    if (fill_level >= 2) begin
      prev = (newest + DEPTH - 1) % DEPTH;
      r.in_frame = (track_x[prev] != px) || (track_y[prev] != py) || (track_z[prev] != pz);
    end
    if (exp_used == EXPECT_DEPTH) begin
      report_mismatch("too many results outstanding", longint'(exp_used), 0);
    end else begin
      expected_ring[exp_tail] = r;
      exp_tail = (exp_tail + 1) % EXPECT_DEPTH;
      exp_used++;
    end
  endtask

  always @(posedge clk) begin
    track_result_t got;
    track_result_t want;
    if (rst) begin
      next_slot     = 0;
      fill_level    = 0;
      lookback      = 7'd30;
      exp_head      = 0;
      exp_tail      = 0;
      exp_used      = 0;
      fail_count    = 0;
      result_count  = 0;
      valid_count   = 0;
    end else begin
      if (cfg_we) lookback = cfg_wdata;

      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        result_count++;
        if (exp_used == 0) begin
          report_mismatch("result with nothing expected", longint'(m_axis_tdata), 0);
        end else begin
          want     = expected_ring[exp_head];
          exp_head = (exp_head + 1) % EXPECT_DEPTH;
          exp_used--;
          if (got.floor_distance != want.floor_distance)
            report_mismatch("floor_distance", got.floor_distance, want.floor_distance);
          if (got.facing_angle != want.facing_angle)
            report_mismatch("facing_angle", longint'($signed(got.facing_angle)),
                            longint'($signed(want.facing_angle)));
          if (got.heading != want.heading)
            report_mismatch("heading", got.heading, want.heading);
          if (got.heading_valid != want.heading_valid)
            report_mismatch("heading_valid", got.heading_valid, want.heading_valid);
          if (got.in_frame != want.in_frame)
            report_mismatch("in_frame", got.in_frame, want.in_frame);
          if (want.heading_valid) valid_count++;
        end
      end

      if (s_axis_tvalid && s_axis_tready) predict_track(s_axis_tdata);
    end
    pending_count = int'(exp_used);
  end

endmodule

>>> test/tb_torso_track_heading_core.sv
`timescale 1ns / 100ps

module tb_torso_track_heading_core;

  logic        clk;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  wire logic   s_axis_tready;
  // pos_x [14:0], pos_y [29:15], pos_z [44:30], zero [47:45]
  logic [47:0] s_axis_tdata  = '0;
  wire logic   m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // floor_distance [14:0], facing_angle [29:15], heading [45:30],
  // heading_valid [46], in_frame [47]
  wire logic [47:0] m_axis_tdata;
  logic        cfg_we        = 1'b0;
  logic [6:0]  cfg_wdata     = '0;

  int fail_count;
  int pending_count;
  int result_count;
  int valid_count;

  int sent_count   = 0;
  int phase_count  = 1;
  int burst_left   = 0;
  int last_x       = 0;
  int last_y       = 0;
  int last_z       = 0;
  int hold_x_left  = 0;
  int hold_z_left  = 0;
  int ready_left   = 0;
  bit ready_level  = 1'b0;

  torso_track_heading_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  tth_track_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .result_count  (result_count),
    .valid_count   (valid_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // result side: random stall runs mixed with long always-ready stretches
  always @(negedge clk) begin
    if (ready_left == 0) begin
      if ($urandom_range(0, 5) == 0) begin
        ready_level = 1'b1;
        ready_left  = $urandom_range(100, 400);
      end else begin
        ready_level = $urandom_range(0, 1);
        ready_left  = $urandom_range(1, 40);
      end
    end else begin
      ready_left--;
    end
    m_axis_tready <= ready_level;
  end

  function automatic int clamp_mm(int v);
    if (v > 16383) return 16383;
    if (v < -16384) return -16384;
    return v;
  endfunction

  function automatic int rand_mm();
    return int'($urandom_range(0, 32767)) - 16384;
  endfunction

  function automatic int edge_mm();
    case ($urandom_range(0, 4))
      0:       return -16384;
      1:       return -1;
      2:       return 0;
      3:       return 1;
      default: return 16383;
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer or after a random idle gap
  task automatic send_position(input int px, input int py, input int pz);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, 15'(pz), 15'(py), 15'(px)};
    last_x = px;
    last_y = py;
    last_z = pz;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    sent_count++;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                              : $urandom_range(0, 15);
      if ($urandom_range(0, 3) == 0) gap = 0;
      else if ($urandom_range(0, 7) == 0) gap = $urandom_range(20, 60);
      else gap = $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // a track that mostly moves smoothly, with jumps, repeats and frozen axes
  task automatic send_track_point();
    int nx;
    int ny;
    int nz;
    nx = last_x;
    ny = last_y;
    nz = last_z;
    case ($urandom_range(0, 9))
      0, 1: begin
        nx = rand_mm();
        ny = rand_mm();
        nz = rand_mm();
      end
      2: ;
      3, 4, 5: begin
        nx = nx + int'($urandom_range(0, 30)) - 15;
        ny = ny + int'($urandom_range(0, 30)) - 15;
        nz = nz + int'($urandom_range(0, 30)) - 15;
      end
      6: nz = nz + int'($urandom_range(0, 4000)) - 2000;
      7: nx = nx + int'($urandom_range(0, 4000)) - 2000;
      8: begin
        nx = edge_mm();
        ny = edge_mm();
        nz = edge_mm();
      end
      default: ny = rand_mm();
    endcase
    // frozen axes give displacements along the other axis only
    if (hold_x_left > 0) begin
      nx = last_x;
      hold_x_left--;
    end else if ($urandom_range(0, 40) == 0) begin
      hold_x_left = $urandom_range(1, 80);
    end
    if (hold_z_left > 0) begin
      nz = last_z;
      hold_z_left--;
    end else if ($urandom_range(0, 40) == 0) begin
      hold_z_left = $urandom_range(1, 80);
    end
    send_position(clamp_mm(nx), clamp_mm(ny), clamp_mm(nz));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic set_lookback(input int value);
    cfg_we    <= 1'b1;
    cfg_wdata <= 7'(value);
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_phase(input int value, input int count);
    drain_results();
    set_lookback(value);
    phase_count++;
    repeat (count) send_track_point();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // axis cases, extremes, repeats, mirrored depth, y-only change
    send_position(0, 0, 0);
    send_position(0, 0, 0);
    send_position(16383, 0, 0);
    send_position(-16384, 0, 0);
    send_position(0, 0, 16383);
    send_position(0, 0, -16384);
    send_position(16383, 16383, 16383);
    send_position(-16384, -16384, -16384);
    send_position(16383, -16384, -16384);
    send_position(-16384, 16383, -16384);
    send_position(1, 0, -1);
    send_position(-1, 0, 1);
    send_position(5, 5, 5);
    send_position(5, 6, 5);
    repeat (120) send_track_point();

    // window is full now: displacement corner cases one frame back
    drain_results();
    set_lookback(2);
    phase_count++;
    send_position(-16384, 0, 0);
    send_position(16383, 0, -1);
    send_position(100, 0, 200);
    send_position(100, 0, 300);
    send_position(200, 0, 300);
    send_position(100, 0, 300);
    send_position(100, 0, 300);
    send_position(100, 5, 300);
    repeat (100) send_track_point();

    run_phase(1, 120);
    run_phase(64, 150);
    run_phase(0, 100);
    run_phase(127, 80);
    run_phase(65, 80);
    run_phase(63, 120);
    repeat (4) run_phase($urandom_range(1, 64), 100);
    repeat (2) run_phase($urandom_range(0, 127), 100);

    drain_results();
    $display("sent %0d positions over %0d lookback settings incl. 0, 1, 64 and above 64",
             sent_count, phase_count);
    $display("checked %0d results, %0d with a valid heading", result_count, valid_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
